### hdl/sensor_normalize_smooth_change_macros.svh
// ----------------------------------------------------------------------------
// sensor_normalize_smooth_change_macros
// assertion macros shared by the sensor normalize and smooth block
// ----------------------------------------------------------------------------
`ifndef SENSOR_NORMALIZE_SMOOTH_CHANGE_MACROS_SVH
`define SENSOR_NORMALIZE_SMOOTH_CHANGE_MACROS_SVH

// same-cycle implication, off while in reset
`define SNSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snsc same-cycle check failed");

// next-cycle implication, off while in reset
`define SNSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snsc next-cycle check failed");

`endif

### hdl/snsc_pkg.sv
// ----------------------------------------------------------------------------
// snsc_pkg
// constants, register indexes and control types of the sensor smoothing block
// ----------------------------------------------------------------------------
package snsc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int VALUE_W         = 16;
  localparam int WEIGHT_W        = 16;
  localparam int LAST_W          = 17;
  localparam int ACC_W           = 31;
  localparam int QBITS           = 16;
  localparam int CNT_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam int ONE_Q15         = 32768;
  localparam int RANGE_MAX_RST   = 4095;
  localparam int WEIGHT_RST      = 3277;
  localparam int THRESH_RST      = 328;
  localparam int LAST_RST        = -32768;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 2'd3;

  typedef struct packed {
    logic start;
    logic step;
  } snsc_ctl_t;

endpackage

### hdl/snsc_div.sv
// ----------------------------------------------------------------------------
// snsc_div
// restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module snsc_div #(
  parameter int SAMPLE_BITS = snsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  snsc_pkg::snsc_ctl_t     ctl,
  input  logic [SAMPLE_BITS-1:0]  num,
  input  logic [SAMPLE_BITS-1:0]  den,
  input  logic                    err,
  output logic                    q_bit
);

  logic [SAMPLE_BITS-1:0] rem_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic                   first_r;
  logic                   err_r;
  logic [SAMPLE_BITS:0]   cand;
  logic                   ge;

  // first step compares the numerator itself, later steps the doubled remainder
  assign cand  = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge    = cand >= {1'b0, den_r};
  assign q_bit = ge & ~err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
      err_r   <= 1'b0;
    end else if (ctl.start) begin
      first_r <= 1'b1;
      err_r   <= err;
    end else if (ctl.step) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= num;
      den_r <= den;
    end else if (ctl.step) begin
      if (ge) begin
        rem_r <= SAMPLE_BITS'(cand - {1'b0, den_r});
      end else begin
        rem_r <= cand[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

### hdl/snsc_mac.sv
// ----------------------------------------------------------------------------
// snsc_mac
// bit-serial weighted sum of new and old value, one bit of each per cycle
// ----------------------------------------------------------------------------
module snsc_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  snsc_pkg::snsc_ctl_t               ctl,
  input  logic [snsc_pkg::WEIGHT_W-1:0]     weight,
  input  logic [snsc_pkg::VALUE_W-1:0]      filt,
  input  logic                              q_bit,
  output logic [snsc_pkg::VALUE_W-1:0]      value
);

  localparam int AW = snsc_pkg::ACC_W;
  localparam int VW = snsc_pkg::VALUE_W;
  localparam int WW = snsc_pkg::WEIGHT_W;
  localparam logic [WW-1:0] ONE = WW'(snsc_pkg::ONE_Q15);

  logic [AW-1:0] acc_r;
  logic [AW-1:0] acc_nxt;
  logic [VW-1:0] fsh_r;
  logic [WW-1:0] w_r;
  logic [WW-1:0] wc_r;
  logic [WW-1:0] w_sat;
  logic          busy_r;

  // weight above one saturates
  assign w_sat = (weight > ONE) ? ONE : weight;

  assign acc_nxt = {acc_r[AW-2:0], 1'b0}
                 + AW'(q_bit ? w_r : '0)
                 + AW'(fsh_r[VW-1] ? wc_r : '0);

  assign value = acc_r[AW-1 -: VW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
      fsh_r <= filt;
      w_r   <= w_sat;
      wc_r  <= ONE - w_sat;
    end else if (ctl.step && busy_r) begin
      acc_r <= acc_nxt;
      fsh_r <= {fsh_r[VW-2:0], 1'b0};
    end
  end

endmodule

### hdl/sensor_normalize_smooth_change.sv
// ----------------------------------------------------------------------------
// sensor_normalize_smooth_change
// clamps and normalizes a converter sample to Q1.15, smooths it with an
// exponential filter and flags moves beyond a threshold
// ----------------------------------------------------------------------------
//  channel  direction  signals
//  in       input      in_valid, in_ready, in_sample
//  out      output     out_valid, out_ready, out_smoothed_value, out_changed,
//                      out_range_error
//  cfg      input      cfg_we, cfg_index, cfg_wdata
//
// a request passes through accept, a run state where the divider hands one
// quotient bit per cycle straight into the bit-serial multiply-add, and a
// finish state for the change test and output load
// reset is synchronous, active low; no memory, so no clearing pass
// a stalled output holds the last cycle until out_ready; the next request is
// accepted while a finished result still waits
// ----------------------------------------------------------------------------
`include "sensor_normalize_smooth_change_macros.svh"

module sensor_normalize_smooth_change #(
  parameter int SAMPLE_BITS = snsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [snsc_pkg::VALUE_W-1:0]        out_smoothed_value,
  output logic                                out_changed,
  output logic                                out_range_error,
  input  logic                                cfg_we,
  input  logic [snsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [snsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int VW = snsc_pkg::VALUE_W;
  localparam int WW = snsc_pkg::WEIGHT_W;
  localparam int LW = snsc_pkg::LAST_W;
  localparam int CW = snsc_pkg::CNT_W;
  localparam logic [SAMPLE_BITS-1:0] RMAX_RST = SAMPLE_BITS'(snsc_pkg::RANGE_MAX_RST);
  localparam logic [CW-1:0]          CNT_LAST = CW'(snsc_pkg::QBITS - 1);
  localparam logic [VW-1:0]          ONE      = VW'(snsc_pkg::ONE_Q15);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [SAMPLE_BITS-1:0] range_min_r;
  logic [SAMPLE_BITS-1:0] range_max_r;
  logic [WW-1:0]          weight_r;
  logic [WW-1:0]          thresh_r;

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;

  logic [VW-1:0]          filtered_r;
  logic [LW-1:0]          last_r;
  logic                   err_r;

  logic                   out_valid_r;
  logic [VW-1:0]          out_value_r;
  logic                   out_changed_r;
  logic                   out_err_r;

  snsc_pkg::snsc_ctl_t    ctl;
  logic                   in_acc;
  logic                   fin_go;
  logic                   err_in;
  logic [SAMPLE_BITS-1:0] s_clamp;
  logic [SAMPLE_BITS-1:0] num;
  logic [SAMPLE_BITS-1:0] den;
  logic                   q_bit;
  logic [VW-1:0]          filt_new;
  logic [LW:0]            diff;
  logic [LW-1:0]          diff_abs;
  logic                   change;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign fin_go   = (state_r == ST_FIN) & (~out_valid_r | out_ready);

  // clamp and offset at accept
  assign err_in  = (range_max_r <= range_min_r);
  assign s_clamp = (in_sample < range_min_r) ? range_min_r :
                   (in_sample > range_max_r) ? range_max_r : in_sample;
  assign num     = s_clamp - range_min_r;
  assign den     = range_max_r - range_min_r;

  assign ctl.start = in_acc;
  assign ctl.step  = (state_r == ST_RUN);

  snsc_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .num   (num),
    .den   (den),
    .err   (err_in),
    .q_bit (q_bit)
  );

  snsc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .weight (weight_r),
    .filt   (filtered_r),
    .q_bit  (q_bit),
    .value  (filt_new)
  );

  // distance from the last reported value
  assign diff     = {2'b00, filt_new} - {last_r[LW-1], last_r};
  assign diff_abs = diff[LW] ? LW'(-diff) : diff[LW-1:0];
  assign change   = diff_abs > {1'b0, thresh_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= '0;
      range_max_r <= RMAX_RST;
      weight_r    <= WW'(snsc_pkg::WEIGHT_RST);
      thresh_r    <= WW'(snsc_pkg::THRESH_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        snsc_pkg::REG_RANGE_MIN: range_min_r <= cfg_wdata[SAMPLE_BITS-1:0];
        snsc_pkg::REG_RANGE_MAX: range_max_r <= cfg_wdata[SAMPLE_BITS-1:0];
        snsc_pkg::REG_WEIGHT:    weight_r    <= cfg_wdata[WW-1:0];
        snsc_pkg::REG_THRESH:    thresh_r    <= cfg_wdata[WW-1:0];
        default: begin
        end
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filtered_r <= '0;
      last_r     <= LW'(snsc_pkg::LAST_RST);
      err_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        err_r <= err_in;
      end
      if (fin_go) begin
        filtered_r <= filt_new;
        if (change) begin
          last_r <= {1'b0, filt_new};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_value_r   <= filt_new;
      out_changed_r <= change;
      out_err_r     <= err_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_value = out_value_r;
  assign out_changed        = out_changed_r;
  assign out_range_error    = out_err_r;

  `SNSC_ASSERT_NEXT(a_accept_runs, clk, rst_n, in_acc, state_r == ST_RUN)
  `SNSC_ASSERT_NEXT(a_run_ends, clk, rst_n, (state_r == ST_RUN) && (cnt_r == CNT_LAST), state_r == ST_FIN)
  `SNSC_ASSERT_SAME(a_out_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FIN)
  `SNSC_ASSERT_SAME(a_filter_range, clk, rst_n, 1'b1, filtered_r <= ONE)

endmodule
